@@ rtl/assert_macros.svh @@
// Assertion macros used by the keyword mask filter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/kmf_pkg.sv @@
// Types and constants of the keyword mask filter.
`default_nettype none
package kmf_pkg;

    localparam int LEN_W = 5;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_SCAN  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [7:0] MASK_CHAR = 8'h2A;

    localparam logic [7:0] FIXED_A0 = 8'hE3;
    localparam logic [7:0] FIXED_A1 = 8'h80;
    localparam logic [7:0] FIXED_A2 = 8'h80;
    localparam logic [7:0] FIXED_B0 = 8'hE2;
    localparam logic [7:0] FIXED_B1 = 8'h80;
    localparam logic [7:0] FIXED_B2 = 8'h8C;
    localparam logic [LEN_W-1:0] FIXED_LEN = 5'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_mask;
        logic       end_of_text;
        logic       load_error;
    } out_t;

endpackage
`default_nettype wire

@@ rtl/kmf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/keyword_mask_filter_top.sv @@
// Top level of the keyword mask filter: keyword store, lookahead window and match sequencer.
// Load, clear and ignored transactions keep busy low. A scan transaction keeps busy high
// through the S_CHECK state after its last result. Per window position it runs S_CHECK,
// S_WORD and S_LEN per stored word, S_CMP per compared byte, then S_WORD, S_EMIT and S_EMIT2
// on a match. The rate is set by the single read port of the keyword byte and length memories.
// Reset clears the word count, load cursor, longest length, window fill and error flag.
`default_nettype none
`include "assert_macros.svh"
module keyword_mask_filter_top #(
    parameter int MAX_WORDS    = 256,
    parameter int MAX_WORD_LEN = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire kmf_pkg::in_t cmd,
    output logic              busy,
    output logic              done,
    output kmf_pkg::out_t     result
);

    localparam int LW    = kmf_pkg::LEN_W;
    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int WA_W  = MAX_WORDS > 1 ? $clog2(MAX_WORDS) : 1;
    localparam int BDEP  = MAX_WORDS * MAX_WORD_LEN;
    localparam int BA_W  = BDEP > 1 ? $clog2(BDEP) : 1;
    localparam int AX_W  = (BA_W + 1 > LW) ? BA_W + 1 : LW + 1;
    localparam int WIN_D = MAX_WORD_LEN >= 3 ? MAX_WORD_LEN : 3;
    localparam int WIN_AW = $clog2(WIN_D);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_WORD  = 7'b0000100,
        S_LEN   = 7'b0001000,
        S_CMP   = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_EMIT2 = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [LW-1:0]    cursor_reg, cursor_next;
    logic [LW-1:0]    longest_reg, longest_next;
    logic [AX_W-1:0]  load_base_reg, load_base_next;
    logic             dropping_reg, dropping_next;
    logic             dropped_reg, dropped_next;
    logic [LW-1:0]    fill_reg, fill_next;
    logic             last_reg, last_next;
    logic [7:0]       win_reg [0:WIN_D-1];
    logic [7:0]       win_next [0:WIN_D-1];

    logic [LW-1:0]    lim_reg, lim_next;
    logic [LW-1:0]    best_reg, best_next;
    logic [LW-1:0]    cand_reg, cand_next;
    logic [LW-1:0]    j_reg, j_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [AX_W-1:0]  base_reg, base_next;

    logic             byte_we, len_we;
    logic [AX_W-1:0]  byte_waddr_x, byte_raddr_x;
    logic [7:0]       byte_rdata;
    logic [LW-1:0]    len_rdata;
    logic [LW-1:0]    cursor_inc;
    logic             accept, drop_now, drop_eff, scan_accept;
    logic [LW-1:0]    thr, lim_calc, drop_amt;
    logic             do_drop, fixed_hit;

    assign accept     = start && (state_reg == S_IDLE);
    assign scan_accept = accept && (cmd.mode == kmf_pkg::MODE_SCAN);
    assign busy       = (state_reg != S_IDLE);
    assign cursor_inc = cursor_reg + LW'(1);
    assign drop_now   = (count_reg >= CNT_W'(MAX_WORDS)) ||
                        (cursor_reg >= LW'(MAX_WORD_LEN));
    assign drop_eff   = dropping_reg || drop_now;
    assign byte_we    = accept && (cmd.mode == kmf_pkg::MODE_LOAD) && !drop_eff;
    assign len_we     = accept && (cmd.mode == kmf_pkg::MODE_LOAD) && cmd.last_byte
                        && !drop_eff;
    assign byte_waddr_x = load_base_reg + AX_W'(cursor_reg);
    assign thr        = (longest_reg != '0) ? longest_reg : LW'(1);
    assign lim_calc   = (fill_reg < longest_reg) ? fill_reg : longest_reg;
    assign fixed_hit  = (lim_calc >= kmf_pkg::FIXED_LEN) &&
        (((win_reg[0] == kmf_pkg::FIXED_A0) && (win_reg[1] == kmf_pkg::FIXED_A1) &&
          (win_reg[2] == kmf_pkg::FIXED_A2)) ||
         ((win_reg[0] == kmf_pkg::FIXED_B0) && (win_reg[1] == kmf_pkg::FIXED_B1) &&
          (win_reg[2] == kmf_pkg::FIXED_B2)));

    kmf_ram #(.WIDTH(8), .DEPTH(BDEP)) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr_x[BA_W-1:0]),
        .wdata (cmd.data_byte),
        .raddr (byte_raddr_x[BA_W-1:0]),
        .rdata (byte_rdata)
    );

    kmf_ram #(.WIDTH(LW), .DEPTH(MAX_WORDS)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (count_reg[WA_W-1:0]),
        .wdata (cursor_inc),
        .raddr (idx_reg[WA_W-1:0]),
        .rdata (len_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        longest_next   = longest_reg;
        load_base_next = load_base_reg;
        dropping_next  = dropping_reg;
        dropped_next   = dropped_reg;
        fill_next      = fill_reg;
        last_next      = last_reg;
        lim_next       = lim_reg;
        best_next      = best_reg;
        cand_next      = cand_reg;
        j_next         = j_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        byte_raddr_x   = base_reg + AX_W'(j_reg) + AX_W'(1);
        do_drop        = 1'b0;
        drop_amt       = LW'(1);
        done           = 1'b0;
        result.out_byte    = kmf_pkg::MASK_CHAR;
        result.is_mask     = 1'b1;
        result.end_of_text = 1'b0;
        result.load_error  = dropped_reg;
        for (int k = 0; k < WIN_D; k++)
        begin
            win_next[k] = win_reg[k];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.mode)
                        kmf_pkg::MODE_LOAD:
                        begin
                            if (!drop_eff)
                            begin
                                cursor_next = cursor_inc;
                            end
                            dropping_next = drop_eff;
                            if (cmd.last_byte)
                            begin
                                if (drop_eff)
                                begin
                                    dropped_next = 1'b1;
                                end
                                else
                                begin
                                    count_next     = count_reg + CNT_W'(1);
                                    load_base_next = load_base_reg + AX_W'(MAX_WORD_LEN);
                                    if (cursor_inc > longest_reg)
                                    begin
                                        longest_next = cursor_inc;
                                    end
                                end
                                cursor_next   = '0;
                                dropping_next = 1'b0;
                            end
                        end
                        kmf_pkg::MODE_SCAN:
                        begin
                            if (fill_reg < LW'(MAX_WORD_LEN))
                            begin
                                win_next[fill_reg[WIN_AW-1:0]] = cmd.data_byte;
                                fill_next = fill_reg + LW'(1);
                            end
                            last_next  = cmd.last_byte;
                            state_next = S_CHECK;
                        end
                        kmf_pkg::MODE_CLEAR:
                        begin
                            count_next     = '0;
                            cursor_next    = '0;
                            longest_next   = '0;
                            load_base_next = '0;
                            dropping_next  = 1'b0;
                            dropped_next   = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if ((fill_reg != '0) && (last_reg || (fill_reg >= thr)))
                begin
                    lim_next   = lim_calc;
                    best_next  = fixed_hit ? kmf_pkg::FIXED_LEN : '0;
                    idx_next   = '0;
                    base_next  = '0;
                    state_next = S_WORD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WORD:
            begin
                state_next = (idx_reg < count_reg) ? S_LEN : S_EMIT;
            end
            S_LEN:
            begin
                byte_raddr_x = base_reg;
                if ((len_rdata != '0) && (len_rdata <= lim_reg) && (len_rdata > best_reg))
                begin
                    cand_next  = len_rdata;
                    j_next     = '0;
                    state_next = S_CMP;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    base_next  = base_reg + AX_W'(MAX_WORD_LEN);
                    state_next = S_WORD;
                end
            end
            S_CMP:
            begin
                if ((byte_rdata != win_reg[j_reg[WIN_AW-1:0]]) ||
                    (j_reg + LW'(1) == cand_reg))
                begin
                    if (byte_rdata == win_reg[j_reg[WIN_AW-1:0]])
                    begin
                        best_next = cand_reg;
                    end
                    idx_next   = idx_reg + CNT_W'(1);
                    base_next  = base_reg + AX_W'(MAX_WORD_LEN);
                    state_next = S_WORD;
                end
                else
                begin
                    j_next = j_reg + LW'(1);
                end
            end
            S_EMIT:
            begin
                done = 1'b1;
                if (best_reg != '0)
                begin
                    state_next = S_EMIT2;
                end
                else
                begin
                    result.out_byte    = win_reg[0];
                    result.is_mask     = 1'b0;
                    result.end_of_text = last_reg && (fill_reg == LW'(1));
                    do_drop            = 1'b1;
                    state_next         = S_CHECK;
                end
            end
            S_EMIT2:
            begin
                done               = 1'b1;
                result.end_of_text = last_reg && (fill_reg == best_reg);
                do_drop            = 1'b1;
                drop_amt           = best_reg;
                state_next         = S_CHECK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_drop)
        begin
            fill_next = fill_reg - drop_amt;
            for (int k = 0; k < WIN_D; k++)
            begin
                if (k + int'(drop_amt) < WIN_D)
                begin
                    win_next[k] = win_reg[k + int'(drop_amt)];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            longest_reg   <= '0;
            load_base_reg <= '0;
            dropping_reg  <= 1'b0;
            dropped_reg   <= 1'b0;
            fill_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            longest_reg   <= longest_next;
            load_base_reg <= load_base_next;
            dropping_reg  <= dropping_next;
            dropped_reg   <= dropped_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        lim_reg  <= lim_next;
        best_reg <= best_next;
        cand_reg <= cand_next;
        j_reg    <= j_next;
        idx_reg  <= idx_next;
        base_reg <= base_next;
        for (int k = 0; k < WIN_D; k++)
        begin
            win_reg[k] <= win_next[k];
        end
    end

    `ASSERT_IMPLY(a_done_busy, clk, rst_n, done, busy, "Result strobe outside a scan.")
    `ASSERT_IMPLY(a_fill_max, clk, rst_n, 1'b1, fill_reg <= LW'(MAX_WORD_LEN), "Window full.")
    `ASSERT_IMPLY(a_best_lim, clk, rst_n, done, best_reg <= fill_reg, "Match too long.")
    `ASSERT_NEXT(a_scan_busy, clk, rst_n, scan_accept, busy, "Scan did not start.")

endmodule
`default_nettype wire
